[sv/cbp_pkg.sv]
// Shared types and constants for the chain bottleneck block.
`default_nettype none

package cbp_pkg;

  localparam int NODES      = 64;
  localparam int NODE_W     = 7;
  localparam int WEIGHT_W   = 20;
  localparam int BEST_W     = 24;
  localparam int TOTAL_W    = 6;
  localparam int MAX_CHAINS = 32;
  localparam int CHAIN_AW   = 5;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam logic [BEST_W-1:0] WEIGHT_START = 24'd9999999;

  typedef struct packed {
    logic                store;
    logic                last;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic                valid;
    logic [NODE_W-1:0]   succ;
    logic [WEIGHT_W-1:0] weight;
  } out_ent_t;

  typedef struct packed {
    logic [NODE_W-1:0]   start_n;
    logic [NODE_W-1:0]   end_n;
    logic [WEIGHT_W-1:0] min_w;
  } chain_ent_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_SCAN,
    ST_SCHK,
    ST_WALK,
    ST_WCHK,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[sv/cbp_front.sv]
// Request intake: range check of edges and a short request queue.
`default_nettype none

module cbp_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_edge_present,
  input  wire logic [cbp_pkg::NODE_W-1:0]   in_source_node,
  input  wire logic [cbp_pkg::NODE_W-1:0]   in_dest_node,
  input  wire logic [cbp_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic                         in_last_edge,
  input  wire cbp_pkg::back_stat_t          stat,
  output logic                              q_valid,
  output cbp_pkg::req_t                     q_head
);

  cbp_pkg::req_t q_mem_r [cbp_pkg::Q_DEPTH];
  logic [cbp_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cbp_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cbp_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic                     full, push, pop;
  logic                     src_ok, dst_ok;
  cbp_pkg::req_t            req;

  assign full    = (cnt_r == (cbp_pkg::Q_AW+1)'(cbp_pkg::Q_DEPTH));
  assign busy    = full || stat.clearing;
  assign push    = start && !busy;
  assign pop     = stat.pop;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  // classify: only in-range edges touch the tables
  assign src_ok = (in_source_node != '0) && (int'(in_source_node) <= cbp_pkg::NODES);
  assign dst_ok = (in_dest_node != '0) && (int'(in_dest_node) <= cbp_pkg::NODES);

  always_comb begin
    req.store  = in_edge_present && src_ok && dst_ok;
    req.last   = in_last_edge;
    req.src    = in_source_node;
    req.dst    = in_dest_node;
    req.weight = in_weight;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req;
    end
  end

endmodule

`default_nettype wire

[sv/cbp_back.sv]
// Edge tables, chain scan and walk, result buffer and result output.
`default_nettype none

module cbp_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [cbp_pkg::NODE_W-1:0]   cfg_wdata,
  input  wire logic                         q_valid,
  input  wire cbp_pkg::req_t                q_head,
  output cbp_pkg::back_stat_t               stat,
  output logic                              out_valid,
  output logic                              out_any_pair,
  output logic [cbp_pkg::NODE_W-1:0]        out_start_node,
  output logic [cbp_pkg::NODE_W-1:0]        out_end_node,
  output logic [cbp_pkg::WEIGHT_W-1:0]      out_min_weight,
  output logic [cbp_pkg::TOTAL_W-1:0]       out_total_pairs,
  output logic                              out_last
);

  localparam int AW = (cbp_pkg::NODES > 1) ? $clog2(cbp_pkg::NODES) : 1;
  localparam int NW = $clog2(cbp_pkg::NODES + 1);

  cbp_pkg::back_state_t state_r, state_nxt;

  cbp_pkg::out_ent_t  mem_out [cbp_pkg::NODES];
  logic               mem_in  [cbp_pkg::NODES];
  cbp_pkg::out_ent_t  rd_out_q;
  logic               rd_in_q;
  cbp_pkg::chain_ent_t chain_buf [cbp_pkg::MAX_CHAINS];

  logic [AW-1:0]                    rd_addr;
  logic                             wr_out_en, wr_in_en;
  logic [AW-1:0]                    wr_out_addr, wr_in_addr;
  cbp_pkg::out_ent_t                wr_out_data;
  logic                             wr_in_data;
  logic                             buf_we;
  cbp_pkg::chain_ent_t              buf_data;

  logic [cbp_pkg::NODE_W-1:0]       node_count_r;
  logic [NW-1:0]                    node_r, node_nxt;
  logic [NW-1:0]                    limit_r, limit_nxt;
  logic [NW-1:0]                    steps_r, steps_nxt;
  logic [cbp_pkg::NODE_W-1:0]       cur_r, cur_nxt;
  logic [cbp_pkg::BEST_W-1:0]       best_r, best_nxt;
  logic [cbp_pkg::TOTAL_W-1:0]      chains_r, chains_nxt;
  logic [cbp_pkg::CHAIN_AW-1:0]     emit_r, emit_nxt;
  logic [AW-1:0]                    clr_r, clr_nxt;

  logic                             ov_nxt, any_nxt, last_nxt;
  logic [cbp_pkg::NODE_W-1:0]       start_nxt, end_nxt;
  logic [cbp_pkg::WEIGHT_W-1:0]     minw_nxt;
  logic [cbp_pkg::TOTAL_W-1:0]      total_nxt;

  logic [NW-1:0]                    node_m1;
  logic [cbp_pkg::NODE_W-1:0]       cur_m1, src_m1, dst_m1;
  logic [cbp_pkg::BEST_W-1:0]       rd_w_ext;
  logic                             scan_done;
  logic                             emit_last;
  cbp_pkg::chain_ent_t              emit_ent;

  assign node_m1   = node_r - 1'b1;
  assign cur_m1    = cur_r - 1'b1;
  assign src_m1    = q_head.src - 1'b1;
  assign dst_m1    = q_head.dst - 1'b1;
  assign rd_w_ext  = cbp_pkg::BEST_W'(rd_out_q.weight);
  assign scan_done = (node_r == limit_r);
  assign emit_ent  = chain_buf[emit_r];
  assign emit_last = ((cbp_pkg::TOTAL_W'(emit_r) + 1'b1) == chains_r);

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    limit_nxt     = limit_r;
    steps_nxt     = steps_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    chains_nxt    = chains_r;
    emit_nxt      = emit_r;
    clr_nxt       = clr_r;
    stat.pop      = 1'b0;
    stat.clearing = (state_r == cbp_pkg::ST_CLEAR);
    rd_addr       = AW'(node_m1);
    wr_out_en     = 1'b0;
    wr_out_addr   = AW'(src_m1);
    wr_out_data   = '{valid: 1'b1, succ: q_head.dst, weight: q_head.weight};
    wr_in_en      = 1'b0;
    wr_in_addr    = AW'(dst_m1);
    wr_in_data    = 1'b1;
    buf_we        = 1'b0;
    buf_data      = '{start_n: cbp_pkg::NODE_W'(node_r), end_n: cur_r,
                      min_w: best_r[cbp_pkg::WEIGHT_W-1:0]};
    ov_nxt        = 1'b0;
    any_nxt       = 1'b0;
    start_nxt     = '0;
    end_nxt       = '0;
    minw_nxt      = '0;
    total_nxt     = '0;
    last_nxt      = 1'b0;

    unique case (state_r)
      cbp_pkg::ST_CLEAR: begin
        wr_out_en   = 1'b1;
        wr_out_addr = clr_r;
        wr_out_data = '0;
        wr_in_en    = 1'b1;
        wr_in_addr  = clr_r;
        wr_in_data  = 1'b0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == AW'(cbp_pkg::NODES - 1)) begin
          clr_nxt   = '0;
          state_nxt = cbp_pkg::ST_LOAD;
        end
      end
      cbp_pkg::ST_LOAD: begin
        if (q_valid) begin
          stat.pop  = 1'b1;
          wr_out_en = q_head.store;
          wr_in_en  = q_head.store;
          if (q_head.last) begin
            chains_nxt = '0;
            emit_nxt   = '0;
            node_nxt   = NW'(1);
            limit_nxt  = (int'(node_count_r) > cbp_pkg::NODES) ?
                         NW'(cbp_pkg::NODES) : NW'(node_count_r);
            state_nxt  = (node_count_r == '0) ? cbp_pkg::ST_EMIT : cbp_pkg::ST_SCAN;
          end
        end
      end
      cbp_pkg::ST_SCAN: begin
        state_nxt = cbp_pkg::ST_SCHK;
      end
      cbp_pkg::ST_SCHK: begin
        if (rd_out_q.valid && !rd_in_q) begin
          cur_nxt   = rd_out_q.succ;
          best_nxt  = (rd_w_ext < cbp_pkg::WEIGHT_START) ? rd_w_ext : cbp_pkg::WEIGHT_START;
          steps_nxt = NW'(1);
          state_nxt = cbp_pkg::ST_WALK;
        end else if (scan_done) begin
          state_nxt = cbp_pkg::ST_EMIT;
        end else begin
          node_nxt  = node_r + 1'b1;
          state_nxt = cbp_pkg::ST_SCAN;
        end
      end
      cbp_pkg::ST_WALK: begin
        rd_addr   = AW'(cur_m1);
        state_nxt = cbp_pkg::ST_WCHK;
      end
      cbp_pkg::ST_WCHK: begin
        if (!rd_out_q.valid) begin
          buf_we     = 1'b1;
          chains_nxt = chains_r + 1'b1;
          if (chains_r == cbp_pkg::TOTAL_W'(cbp_pkg::MAX_CHAINS - 1) || scan_done) begin
            state_nxt = cbp_pkg::ST_EMIT;
          end else begin
            node_nxt  = node_r + 1'b1;
            state_nxt = cbp_pkg::ST_SCAN;
          end
        end else if (steps_r == NW'(cbp_pkg::NODES)) begin
          // drop: walk entered a cycle
          if (scan_done) begin
            state_nxt = cbp_pkg::ST_EMIT;
          end else begin
            node_nxt  = node_r + 1'b1;
            state_nxt = cbp_pkg::ST_SCAN;
          end
        end else begin
          best_nxt  = (rd_w_ext < best_r) ? rd_w_ext : best_r;
          cur_nxt   = rd_out_q.succ;
          steps_nxt = steps_r + 1'b1;
          state_nxt = cbp_pkg::ST_WALK;
        end
      end
      cbp_pkg::ST_EMIT: begin
        ov_nxt = 1'b1;
        if (chains_r == '0) begin
          last_nxt  = 1'b1;
          state_nxt = cbp_pkg::ST_CLEAR;
        end else begin
          any_nxt   = 1'b1;
          start_nxt = emit_ent.start_n;
          end_nxt   = emit_ent.end_n;
          minw_nxt  = emit_ent.min_w;
          total_nxt = chains_r;
          last_nxt  = emit_last;
          emit_nxt  = emit_r + 1'b1;
          if (emit_last) begin
            state_nxt = cbp_pkg::ST_CLEAR;
          end
        end
      end
      default: begin
        state_nxt = cbp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cbp_pkg::ST_CLEAR;
      clr_r        <= '0;
      chains_r     <= '0;
      emit_r       <= '0;
      node_r       <= '0;
      limit_r      <= '0;
      node_count_r <= cbp_pkg::NODE_W'(64);
      out_valid    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      chains_r  <= chains_nxt;
      emit_r    <= emit_nxt;
      node_r    <= node_nxt;
      limit_r   <= limit_nxt;
      out_valid <= ov_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    steps_r         <= steps_nxt;
    cur_r           <= cur_nxt;
    best_r          <= best_nxt;
    out_any_pair    <= any_nxt;
    out_start_node  <= start_nxt;
    out_end_node    <= end_nxt;
    out_min_weight  <= minw_nxt;
    out_total_pairs <= total_nxt;
    out_last        <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_out_en) begin
      mem_out[wr_out_addr] <= wr_out_data;
    end
    rd_out_q <= mem_out[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_in_en) begin
      mem_in[wr_in_addr] <= wr_in_data;
    end
    rd_in_q <= mem_in[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      chain_buf[chains_r[cbp_pkg::CHAIN_AW-1:0]] <= buf_data;
    end
  end

endmodule

`default_nettype wire

[sv/chain_bottleneck_pairs.sv]
// Top level of the chain bottleneck block: request queue and chain engine.
`default_nettype none

// Requests carry one directed weighted edge each and are taken at one per
// cycle through a four-entry queue while busy is low. The request marked
// last_edge starts a scan of nodes 1..node_count (capped at NODES), each
// node read in SCAN and SCHK and each edge walked along a chain (up to NODES
// per chain) in WALK and WCHK, over one read port of the edge table. Results
// follow on consecutive cycles, one per chain in start-node order (or one
// empty result), each marked by out_valid for a single cycle; the receiver
// cannot stall them, so it must take every strobe. After each run, and after
// reset, all NODES entries of the edge tables are wiped while busy stays high.
module chain_bottleneck_pairs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_edge_present,
  input  wire logic [cbp_pkg::NODE_W-1:0]   in_source_node,
  input  wire logic [cbp_pkg::NODE_W-1:0]   in_dest_node,
  input  wire logic [cbp_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic                         in_last_edge,
  input  wire logic                         cfg_we,
  input  wire logic [cbp_pkg::NODE_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  output logic                              out_any_pair,
  output logic [cbp_pkg::NODE_W-1:0]        out_start_node,
  output logic [cbp_pkg::NODE_W-1:0]        out_end_node,
  output logic [cbp_pkg::WEIGHT_W-1:0]      out_min_weight,
  output logic [cbp_pkg::TOTAL_W-1:0]       out_total_pairs,
  output logic                              out_last
);

  cbp_pkg::back_stat_t stat;
  cbp_pkg::req_t       q_head;
  logic                q_valid;

  cbp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_edge_present(in_edge_present),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .in_weight      (in_weight),
    .in_last_edge   (in_last_edge),
    .stat           (stat),
    .q_valid        (q_valid),
    .q_head         (q_head)
  );

  cbp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_any_pair   (out_any_pair),
    .out_start_node (out_start_node),
    .out_end_node   (out_end_node),
    .out_min_weight (out_min_weight),
    .out_total_pairs(out_total_pairs),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

[sv/cbp_check.sv]
// Port-level checks on the result stream of the chain bottleneck block.
`default_nettype none

module cbp_check (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_any_pair,
  input wire logic [cbp_pkg::NODE_W-1:0]   out_start_node,
  input wire logic [cbp_pkg::TOTAL_W-1:0]  out_total_pairs,
  input wire logic                         out_last
);

  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_pair |-> out_last && out_total_pairs == '0)
    else $error("empty result not alone or carries a count");

  a_chain_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_any_pair |-> out_total_pairs != '0 && out_start_node != '0)
    else $error("chain result without count or start node");

  a_run_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && $stable(out_total_pairs))
    else $error("run results not back to back with one count");

  a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_any_pair && !out_last |=> out_start_node > $past(out_start_node))
    else $error("chain start nodes not ascending");

  a_gap_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after final result of a run");

endmodule

bind chain_bottleneck_pairs cbp_check u_cbp_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_any_pair   (out_any_pair),
  .out_start_node (out_start_node),
  .out_total_pairs(out_total_pairs),
  .out_last       (out_last)
);

`default_nettype wire
